// ===== sv/ipc_pkg.sv =====
// ----------------------------------------------------------------------------
// ipc_pkg
// Shared types and constants for the incremental PI current loop: register
// indexes, microcode word layout and the datapath widths.
// ----------------------------------------------------------------------------
package ipc_pkg;

   localparam int DATA_W    = 16;
   localparam int ERR_W     = 17;
   localparam int DELTA_W   = 18;
   localparam int MUL_A_W   = 17;
   localparam int MUL_B_W   = 18;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int ACC_W     = PROD_W + 1;
   localparam int FRAC_GAIN = 12;
   localparam int FRAC_OUT  = 14;
   localparam int INC_W     = ACC_W - FRAC_GAIN;
   localparam int SUM_W     = INC_W + 1;
   localparam int CSR_IDX_W = 3;
   localparam int PC_W      = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_REFERENCE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PGAIN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IGAIN     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTMIN    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTMAX    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD    = 3'd5;

   localparam logic [DATA_W-1:0] REFERENCE_RST = 16'd16384;
   localparam logic [DATA_W-1:0] OUTMAX_RST    = 16'd16384;
   localparam logic [DATA_W-1:0] COMPARE_MAX   = 16'hFFFF;
   localparam logic [ACC_W-1:0]  ROUND_HALF    = ACC_W'(2048);

   localparam logic [PC_W-1:0] STEP_IDLE  = 3'd0;
   localparam logic [PC_W-1:0] STEP_KI    = 3'd1;
   localparam logic [PC_W-1:0] STEP_KP    = 3'd2;
   localparam logic [PC_W-1:0] STEP_CLAMP = 3'd3;
   localparam logic [PC_W-1:0] STEP_PWM   = 3'd4;

   typedef enum logic [1:0] {
      WAIT_NONE,
      WAIT_REQ,
      WAIT_OUT
   } wait_type;

   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_KI_ERR,
      MUL_KP_DELTA,
      MUL_PERIOD_OUT
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef struct packed {
      wait_type    wait_on;
      logic        last;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        load_err;
      logic        update_state;
      logic        emit;
   } ucode_type;

   typedef struct packed {
      logic      go;
      ucode_type word;
   } seq_ctl_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] reference;
      logic signed [DATA_W-1:0] pgain;
      logic signed [DATA_W-1:0] igain;
      logic signed [DATA_W-1:0] outmin;
      logic signed [DATA_W-1:0] outmax;
      logic        [DATA_W-1:0] period;
   } cfg_type;

endpackage

// ===== sv/incremental_pi_pwm_current_loop_top.sv =====
// ----------------------------------------------------------------------------
// incremental_pi_pwm_current_loop_top
// Velocity-form PI current regulator with PWM compare output.
// ----------------------------------------------------------------------------
// Each accepted current sample runs four microprogram steps after the idle
// step that accepts it (integral product, proportional product, clamp, PWM
// scaling); the three product steps share one 17x18 multiplier. The result
// beat is registered when the PWM step completes. A new sample is taken only
// once the sequencer is back at its idle step, so samples do not overlap.
// The result register holds a finished beat while the next sample is
// accepted; the final step waits only if the previous result beat has not yet
// been taken. Registers may be written at any time the block is idle;
// csr_ready is always high.
// ----------------------------------------------------------------------------
module incremental_pi_pwm_current_loop_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [ipc_pkg::DATA_W-1:0]   req_current_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic        [ipc_pkg::DATA_W-1:0]   rsp_compare_value,
   output logic signed [ipc_pkg::DATA_W-1:0]   rsp_duty_level,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic        [ipc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [ipc_pkg::DATA_W-1:0]   csr_wdata
);

   ipc_pkg::cfg_type     cfg_ff;
   ipc_pkg::seq_ctl_type ctl;
   logic                 idle;
   logic                 out_free;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic signed [ipc_pkg::DATA_W-1:0] held_output;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reference <= ipc_pkg::REFERENCE_RST;
         cfg_ff.pgain     <= '0;
         cfg_ff.igain     <= '0;
         cfg_ff.outmin    <= '0;
         cfg_ff.outmax    <= ipc_pkg::OUTMAX_RST;
         cfg_ff.period    <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ipc_pkg::CSR_REFERENCE: cfg_ff.reference <= csr_wdata;
            ipc_pkg::CSR_PGAIN:     cfg_ff.pgain     <= csr_wdata;
            ipc_pkg::CSR_IGAIN:     cfg_ff.igain     <= csr_wdata;
            ipc_pkg::CSR_OUTMIN:    cfg_ff.outmin    <= csr_wdata;
            ipc_pkg::CSR_OUTMAX:    cfg_ff.outmax    <= csr_wdata;
            ipc_pkg::CSR_PERIOD:    cfg_ff.period    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   ipc_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .idle      (idle),
      .ctl       (ctl)
   );

   ipc_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .cfg           (cfg_ff),
      .sample        (req_current_sample),
      .held_output   (held_output),
      .compare_value (rsp_compare_value),
      .duty_level    (rsp_duty_level)
   );

   assign req_stall = !idle;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.go && ctl.word.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("sequencer did not leave idle after an accepted beat");

   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (ctl.go && ctl.word.emit) |=> rsp_valid)
      else $error("result beat not presented after emit step");

   a_held_above_min: assert property (@(posedge clock) disable iff (reset)
      (ctl.go && ctl.word.update_state) |=> (held_output >= cfg_ff.outmin))
      else $error("clamped output below minimum");

   a_negative_no_compare: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_duty_level[ipc_pkg::DATA_W-1]) |-> (rsp_compare_value == '0))
      else $error("negative duty produced nonzero compare value");

endmodule

// ===== sv/ipc_ucode_rom.sv =====
// ----------------------------------------------------------------------------
// ipc_ucode_rom
// Microprogram store: one control word per step of the regulator update.
// ----------------------------------------------------------------------------
module ipc_ucode_rom (
   input  logic [ipc_pkg::PC_W-1:0] pc,
   output ipc_pkg::ucode_type       word
);

   always_comb begin
      word = '{wait_on: ipc_pkg::WAIT_NONE, last: 1'b0, mul_sel: ipc_pkg::MUL_NONE,
               acc_op: ipc_pkg::ACC_HOLD, load_err: 1'b0, update_state: 1'b0,
               emit: 1'b0};
      case (pc)
         ipc_pkg::STEP_IDLE: begin
            word.wait_on  = ipc_pkg::WAIT_REQ;
            word.load_err = 1'b1;
         end
         ipc_pkg::STEP_KI: begin
            word.mul_sel = ipc_pkg::MUL_KI_ERR;
            word.acc_op  = ipc_pkg::ACC_LOAD;
         end
         ipc_pkg::STEP_KP: begin
            word.mul_sel = ipc_pkg::MUL_KP_DELTA;
            word.acc_op  = ipc_pkg::ACC_ADD;
         end
         ipc_pkg::STEP_CLAMP: begin
            word.update_state = 1'b1;
         end
         ipc_pkg::STEP_PWM: begin
            word.wait_on = ipc_pkg::WAIT_OUT;
            word.mul_sel = ipc_pkg::MUL_PERIOD_OUT;
            word.emit    = 1'b1;
            word.last    = 1'b1;
         end
         default: begin
            word.last = 1'b1;
         end
      endcase
   end

endmodule

// ===== sv/ipc_sequencer.sv =====
// ----------------------------------------------------------------------------
// ipc_sequencer
// Step counter with wait conditions; fetches the control word and advances.
// ----------------------------------------------------------------------------
module ipc_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     out_free,
   output logic                     idle,
   output ipc_pkg::seq_ctl_type     ctl
);

   logic [ipc_pkg::PC_W-1:0] pc_ff;
   logic [ipc_pkg::PC_W-1:0] pc_in;
   ipc_pkg::ucode_type       word;
   logic                     go;

   ipc_ucode_rom u_rom (
      .pc   (pc_ff),
      .word (word)
   );

   always_comb begin
      case (word.wait_on)
         ipc_pkg::WAIT_NONE: go = 1'b1;
         ipc_pkg::WAIT_REQ:  go = req_valid;
         ipc_pkg::WAIT_OUT:  go = out_free;
         default:            go = 1'b0;
      endcase
   end

   always_comb begin
      pc_in = pc_ff;
      if (go) begin
         pc_in = word.last ? ipc_pkg::STEP_IDLE : pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ipc_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign idle     = (pc_ff == ipc_pkg::STEP_IDLE);
   assign ctl.go   = go;
   assign ctl.word = word;

endmodule

// ===== sv/ipc_datapath.sv =====
// ----------------------------------------------------------------------------
// ipc_datapath
// Error registers, shared multiplier, accumulator, rounding and clamp, PWM
// scaling and the result payload registers.
// ----------------------------------------------------------------------------
module ipc_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  ipc_pkg::seq_ctl_type               ctl,
   input  ipc_pkg::cfg_type                   cfg,
   input  logic signed [ipc_pkg::DATA_W-1:0]  sample,
   output logic signed [ipc_pkg::DATA_W-1:0]  held_output,
   output logic        [ipc_pkg::DATA_W-1:0]  compare_value,
   output logic signed [ipc_pkg::DATA_W-1:0]  duty_level
);

   logic signed [ipc_pkg::ERR_W-1:0]   err_ff;
   logic signed [ipc_pkg::ERR_W-1:0]   err_in;
   logic signed [ipc_pkg::ERR_W-1:0]   prev_err_ff;
   logic signed [ipc_pkg::DELTA_W-1:0] delta_ff;
   logic signed [ipc_pkg::DELTA_W-1:0] delta_in;
   logic signed [ipc_pkg::ACC_W-1:0]   acc_ff;
   logic signed [ipc_pkg::ACC_W-1:0]   acc_in;
   logic signed [ipc_pkg::DATA_W-1:0]  held_ff;
   logic signed [ipc_pkg::DATA_W-1:0]  held_in;
   logic        [ipc_pkg::DATA_W-1:0]  cmp_ff;
   logic        [ipc_pkg::DATA_W-1:0]  cmp_in;
   logic signed [ipc_pkg::DATA_W-1:0]  duty_ff;

   logic signed [ipc_pkg::MUL_A_W-1:0] mul_a;
   logic signed [ipc_pkg::MUL_B_W-1:0] mul_b;
   logic signed [ipc_pkg::PROD_W-1:0]  prod;
   logic signed [ipc_pkg::ACC_W-1:0]   rnd_sum;
   logic signed [ipc_pkg::INC_W-1:0]   inc;
   logic signed [ipc_pkg::SUM_W-1:0]   total;
   logic signed [ipc_pkg::SUM_W-1:0]   hi_ext;
   logic signed [ipc_pkg::SUM_W-1:0]   lo_ext;
   logic signed [ipc_pkg::SUM_W-1:0]   upper_cut;
   logic signed [ipc_pkg::SUM_W-1:0]   clamped;

   assign err_in   = ipc_pkg::ERR_W'(cfg.reference) - ipc_pkg::ERR_W'(sample);
   assign delta_in = ipc_pkg::DELTA_W'(err_in) - ipc_pkg::DELTA_W'(prev_err_ff);

   always_comb begin
      case (ctl.word.mul_sel)
         ipc_pkg::MUL_KI_ERR: begin
            mul_a = ipc_pkg::MUL_A_W'(cfg.igain);
            mul_b = ipc_pkg::MUL_B_W'(err_ff);
         end
         ipc_pkg::MUL_KP_DELTA: begin
            mul_a = ipc_pkg::MUL_A_W'(cfg.pgain);
            mul_b = delta_ff;
         end
         ipc_pkg::MUL_PERIOD_OUT: begin
            mul_a = $signed({1'b0, cfg.period});
            mul_b = ipc_pkg::MUL_B_W'(held_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   always_comb begin
      case (ctl.word.acc_op)
         ipc_pkg::ACC_LOAD: acc_in = ipc_pkg::ACC_W'(prod);
         ipc_pkg::ACC_ADD:  acc_in = acc_ff + ipc_pkg::ACC_W'(prod);
         default:           acc_in = acc_ff;
      endcase
   end

   // round half up from Q.12 to whole units, then add and clamp: maximum first, minimum last
   assign rnd_sum   = acc_ff + $signed(ipc_pkg::ROUND_HALF);
   assign inc       = $signed(rnd_sum[ipc_pkg::ACC_W-1:ipc_pkg::FRAC_GAIN]);
   assign total     = ipc_pkg::SUM_W'(held_ff) + ipc_pkg::SUM_W'(inc);
   assign hi_ext    = ipc_pkg::SUM_W'(cfg.outmax);
   assign lo_ext    = ipc_pkg::SUM_W'(cfg.outmin);
   assign upper_cut = (total > hi_ext) ? hi_ext : total;
   assign clamped   = (upper_cut < lo_ext) ? lo_ext : upper_cut;
   assign held_in   = clamped[ipc_pkg::DATA_W-1:0];

   always_comb begin
      if (held_ff <= 0) begin
         cmp_in = '0;
      end else if (|prod[ipc_pkg::PROD_W-1:ipc_pkg::FRAC_OUT+ipc_pkg::DATA_W]) begin
         cmp_in = ipc_pkg::COMPARE_MAX;
      end else begin
         cmp_in = prod[ipc_pkg::FRAC_OUT+ipc_pkg::DATA_W-1:ipc_pkg::FRAC_OUT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_err_ff <= '0;
         held_ff     <= '0;
      end else if (ctl.go && ctl.word.update_state) begin
         prev_err_ff <= err_ff;
         held_ff     <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.go && ctl.word.load_err) begin
         err_ff   <= err_in;
         delta_ff <= delta_in;
      end
      if (ctl.go) begin
         acc_ff <= acc_in;
      end
      if (ctl.go && ctl.word.emit) begin
         cmp_ff  <= cmp_in;
         duty_ff <= held_ff;
      end
   end

   assign held_output   = held_ff;
   assign compare_value = cmp_ff;
   assign duty_level    = duty_ff;

endmodule
